@@ src/transient_shaper_defines.svh @@
// Assertion macros used by the transient shaper queue.
`ifndef TRANSIENT_SHAPER_DEFINES_SVH
`define TRANSIENT_SHAPER_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define TS_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TS_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

@@ src/ts_pkg.sv @@
// ---------------------------------------------------------------------------
// ts_pkg
// Shared widths, constants and types of the transient shaper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package ts_pkg;
  localparam int SampleW = 24;
  localparam int OutW    = 28;
  localparam int CfgW    = 16;
  localparam int IdxW    = 2;
  localparam int QueueDepthDefault = 2;
  localparam logic [IdxW-1:0] RegFastCoeff = 2'd0;
  localparam logic [IdxW-1:0] RegSlowCoeff = 2'd1;
  localparam logic [IdxW-1:0] RegGain      = 2'd2;
  localparam logic [IdxW-1:0] RegSatEn     = 2'd3;
  localparam logic [16:0] KFastScale = 17'd39322;
  localparam logic [16:0] KSlowScale = 17'd19661;
  localparam logic [23:0] MagMax = 24'd8388608;

  // Classified item handed from front to back.
  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic [23:0]               amount;
  } ts_item_t;

  typedef struct packed {
    logic [15:0] gain;
    logic        sat_en;
  } ts_back_cfg_t;
endpackage

@@ src/ts_stream_if.sv @@
// ---------------------------------------------------------------------------
// ts_stream_if
// Valid/ready channel carrying one payload per beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
interface ts_stream_if #(parameter int W = 24) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/ts_front.sv @@
// ---------------------------------------------------------------------------
// ts_front
// Envelope followers: takes samples, updates both envelopes
// with one shared multiplier and emits the transient amount.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module ts_front import ts_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [15:0]               fast_coeff,
  input  logic [15:0]               slow_coeff,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [SampleW-1:0] in_sample,
  output logic                      out_valid,
  input  logic                      out_ready,
  output ts_item_t                  out_item
);
  typedef enum logic [2:0] {S_IDLE, S_KF, S_KS, S_DF, S_DS, S_OUT} state_t;
  state_t state;
  logic [23:0] fast_env, slow_env, mag;
  logic signed [SampleW-1:0] smp;
  logic [16:0] kf, ks;
  logic [23:0] m_a;
  logic [16:0] m_b;
  logic [40:0] prod;
  logic [24:0] abs_s;
  logic [23:0] amount;

  assign abs_s = in_sample[SampleW-1] ? 25'(-$signed({in_sample[23], in_sample}))
                                      : 25'({1'b0, in_sample});
  always_comb begin
    m_a = '0;
    m_b = '0;
    unique case (state)
      S_KF: begin m_a = 24'(fast_coeff); m_b = KFastScale; end
      S_KS: begin m_a = 24'(slow_coeff); m_b = KSlowScale; end
      S_DF: begin m_a = fast_env - mag; m_b = kf; end
      S_DS: begin m_a = slow_env - mag; m_b = ks; end
      default: ;
    endcase
  end
  assign prod = 41'(m_a) * 41'(m_b) + 41'd32768;
  assign amount = (fast_env > slow_env) ? fast_env - slow_env : 24'd0;
  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fast_env <= '0;
      slow_env <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          smp <= in_sample;
          mag <= (abs_s > 25'(MagMax)) ? MagMax : abs_s[23:0];
          state <= S_KF;
        end
        S_KF: begin kf <= prod[32:16]; state <= S_KS; end
        S_KS: begin ks <= prod[32:16]; state <= S_DF; end
        S_DF: begin
          if (mag > fast_env) fast_env <= mag;
          else fast_env <= fast_env - prod[39:16];
          state <= S_DS;
        end
        S_DS: begin
          if (mag > slow_env) slow_env <= mag;
          else slow_env <= slow_env - prod[39:16];
          state <= S_OUT;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
  assign out_item.sample = smp;
  assign out_item.amount = amount;
endmodule

@@ src/ts_queue.sv @@
// ---------------------------------------------------------------------------
// ts_queue
// Short register FIFO between the front and the back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "transient_shaper_defines.svh"
module ts_queue import ts_pkg::*; #(
  parameter int Depth = QueueDepthDefault
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  ts_item_t in_item,
  output logic     out_valid,
  input  logic     out_ready,
  output ts_item_t out_item
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  ts_item_t mem [Depth];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;
  logic push, pop;
  assign in_ready = (cnt != (AW+1)'(Depth));
  assign out_valid = (cnt != '0);
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;
  assign out_item = mem[rp];
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(Depth-1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == AW'(Depth-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) mem[wp] <= in_item;
  end
  `TS_ASSERT_IMP(a_no_over, clk, rst, cnt == (AW+1)'(Depth), !push)
  `TS_ASSERT_NXT(a_cnt_up, clk, rst, push && !pop, cnt == $past(cnt) + 1'b1)
  `TS_ASSERT_NXT(a_cnt_dn, clk, rst, pop && !push, cnt == $past(cnt) - 1'b1)
endmodule

@@ src/ts_back.sv @@
// ---------------------------------------------------------------------------
// ts_back
// Gain, sum and soft clip with a radix-2 restoring divider.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module ts_back import ts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ts_back_cfg_t          cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ts_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [OutW-1:0] shaped,
  output logic [23:0]           amount
);
  typedef enum logic [2:0] {S_IDLE, S_MUL, S_SUM, S_DIV, S_FIN, S_OUT} state_t;
  state_t state;
  logic signed [SampleW-1:0] smp;
  logic [39:0] comp_p;
  logic signed [27:0] y;
  logic neg;
  logic [26:0] mag;
  logic [55:0] rem;
  logic [55:0] num;
  logic [29:0] den;
  logic [29:0] den_init;
  logic [29:0] quot;
  logic [5:0]  bcnt;
  logic [56:0] trial;
  logic [26:0] e;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign e = mag - 27'd16777216;
  assign den_init = 30'd41943040 + 30'({e, 2'b00});
  assign trial = {rem, num[55]} - 57'(den);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          smp <= in_item.sample;
          amount <= in_item.amount;
          state <= S_MUL;
        end
        S_MUL: begin
          comp_p <= 40'(amount) * 40'(cfg.gain) + 40'd4096;
          state <= S_SUM;
        end
        S_SUM: begin
          y <= 28'(smp) + 28'(comp_p[39:13]);
          state <= S_FIN;
          bcnt <= '0;
        end
        S_FIN: begin
          neg <= y[27];
          mag <= y[27] ? 27'(-y) : 27'(y);
          if (cfg.sat_en && ((y[27] ? 28'(-y) : y) > 28'sd16777216)) begin
            state <= S_DIV;
          end else begin
            shaped <= y;
            state <= S_OUT;
          end
          bcnt <= '0;
        end
        S_DIV: begin
          // First cycle loads operands; then one quotient bit per cycle.
          if (bcnt == 6'd0) begin
            den <= den_init;
            // Five times the excess, scaled by 2^23, as two shifted copies.
            num <= 56'({e, 25'd0}) + 56'({e, 23'd0}) + 56'(den_init >> 1);
            rem <= '0;
            quot <= '0;
            bcnt <= 6'd1;
          end else if (bcnt <= 6'd56) begin
            if (!trial[56]) begin
              rem <= trial[55:0];
              quot <= {quot[28:0], 1'b1};
            end else begin
              rem <= {rem[54:0], num[55]};
              quot <= {quot[28:0], 1'b0};
            end
            num <= {num[54:0], 1'b0};
            bcnt <= bcnt + 1'b1;
          end else begin
            shaped <= neg ? -(28'sd16777216 + 28'(quot)) : 28'sd16777216 + 28'(quot);
            state <= S_OUT;
          end
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ src/transient_shaper.sv @@
// Transient shaper: one 24-bit sample per beat in, one shaped sample and
// transient amount out. The front updates both envelopes through one
// shared multiplier; the back runs its one-bit-a-cycle divider only when
// the soft clipper engages. A queue, two entries deep by default, between
// them lets the front run ahead.
// ---------------------------------------------------------------------------
// transient_shaper
// Top level: configuration registers, front, queue and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module transient_shaper import ts_pkg::*; #(
  parameter int QueueDepth = QueueDepthDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [IdxW-1:0] cfg_index,
  input  logic [CfgW-1:0] cfg_data,
  ts_stream_if.sink       in_ch,
  ts_stream_if.source     out_ch
);
  logic [15:0] fast_coeff, slow_coeff, gain;
  logic sat_en;
  always_ff @(posedge clk) begin
    if (rst) begin
      fast_coeff <= '0; slow_coeff <= '0; gain <= 16'd8192; sat_en <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegFastCoeff: fast_coeff <= cfg_data;
        RegSlowCoeff: slow_coeff <= cfg_data;
        RegGain:      gain <= cfg_data;
        RegSatEn:     sat_en <= cfg_data[0];
        default: ;
      endcase
    end
  end
  logic fv, fr, bv, br;
  ts_item_t fi, bi;
  ts_back_cfg_t bcfg;
  logic signed [OutW-1:0] shaped;
  logic [23:0] amt;
  assign bcfg.gain = gain;
  assign bcfg.sat_en = sat_en;
  ts_front u_front (.clk, .rst, .fast_coeff, .slow_coeff,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_sample(in_ch.data[SampleW-1:0]),
    .out_valid(fv), .out_ready(fr), .out_item(fi));
  ts_queue #(.Depth(QueueDepth)) u_queue (.clk, .rst, .in_valid(fv), .in_ready(fr),
    .in_item(fi), .out_valid(bv), .out_ready(br), .out_item(bi));
  ts_back u_back (.clk, .rst, .cfg(bcfg), .in_valid(bv), .in_ready(br), .in_item(bi),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .shaped, .amount(amt));
  assign out_ch.data = {amt, shaped};
endmodule

@@ dv/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the transient shaper. A clocked driver feeds
// samples from a queue; a clocked monitor compares each output beat with a
// bit-exact envelope, gain and soft-clip predictor updated on input beats.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  import ts_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles   = 120;
  localparam int HoldCycles    = 400;

  typedef struct {
    logic [OutW-1:0] shaped;
    logic [23:0]     amount;
  } shaped_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic            cfg_we = 1'b0;
  logic [IdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_data = '0;

  ts_stream_if #(.W(SampleW))   in_if ();
  ts_stream_if #(.W(OutW + 24)) out_if ();

  transient_shaper uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_if.sink), .out_ch(out_if.source)
  );

  always #1 clk = ~clk;

  // Predictor state and register copies.
  logic [15:0] fast_k_reg, slow_k_reg, gain_reg;
  logic        sat_reg;
  longint      fast_env, slow_env;

  logic [SampleW-1:0] sample_queue[$];
  shaped_beat_t       expected_beats[$];
  int  mismatches = 0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;
  int  src_gap = 0;
  int  snk_gap = 0;
  int  hold_left = 0;
  int  stall_cycles = 0;

  function automatic longint track(longint env, longint mag, longint k);
    if (mag > env) return mag;
    return env - (((env - mag) * k + 32768) >>> 16);
  endfunction

  function automatic shaped_beat_t shape_sample(logic [SampleW-1:0] raw);
    shaped_beat_t r;
    longint s, mag, amt, y, m, e, num, den;
    s = longint'($signed(raw));
    mag = (s < 0) ? -s : s;
    fast_env = track(fast_env, mag, (longint'(fast_k_reg) * 39322 + 32768) >>> 16);
    slow_env = track(slow_env, mag, (longint'(slow_k_reg) * 19661 + 32768) >>> 16);
    amt = (fast_env > slow_env) ? fast_env - slow_env : 0;
    y = s + ((amt * longint'(gain_reg) + 4096) >>> 13);
    if (sat_reg) begin
      m = (y < 0) ? -y : y;
      if (m > 64'd16777216) begin
        e = m - 16777216;
        num = 5 * e * 8388608;
        den = 5 * 8388608 + 4 * e;
        m = 16777216 + (num + den / 2) / den;
        y = (y < 0) ? -m : m;
      end
    end
    if (y > 134217727) y = 134217727;
    if (y < -134217728) y = -134217728;
    r.shaped = y[OutW-1:0];
    r.amount = amt[23:0];
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // Driver: also feeds the predictor on every accepted input beat.
  always @(posedge clk) begin
    if (rst) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
    end else begin
      if (in_if.valid && in_if.ready) expected_beats.push_back(shape_sample(in_if.data));
      if (!in_if.valid || in_if.ready) begin
        if (src_gap > 0) begin
          in_if.valid <= 1'b0;
          src_gap--;
        end else if (sample_queue.size() > 0) begin
          in_if.valid <= 1'b1;
          in_if.data  <= sample_queue.pop_front();
          if (!quiet && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 8);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver with random stalls and one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_if.ready <= 1'b0;
    end else begin
      if (hold_req && hold_left == 0) begin
        hold_left = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) snk_gap = $urandom_range(1, 8);
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    shaped_beat_t want;
    logic [OutW-1:0] got_shaped;
    logic [23:0]     got_amount;
    if (!rst && out_if.valid && out_if.ready) begin
      {got_amount, got_shaped} = out_if.data;
      if (expected_beats.size() == 0) begin
        report("unexpected beat", longint'($signed(got_shaped)), 0);
      end else begin
        want = expected_beats.pop_front();
        if (got_shaped !== want.shaped)
          report("shaped_sample", longint'($signed(got_shaped)), longint'($signed(want.shaped)));
        if (got_amount !== want.amount)
          report("transient_amount", longint'(got_amount), longint'(want.amount));
      end
    end
  end

  // Watchdog on cycles with no beat on either channel.
  always @(posedge clk) begin
    if (rst || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(logic [IdxW-1:0] idx, logic [CfgW-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      RegFastCoeff: fast_k_reg = value;
      RegSlowCoeff: slow_k_reg = value;
      RegGain:      gain_reg = value;
      RegSatEn:     sat_reg = value[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [15:0] fk, logic [15:0] sk, logic [15:0] g, logic sat);
    write_reg(RegFastCoeff, fk);
    write_reg(RegSlowCoeff, sk);
    write_reg(RegGain, g);
    write_reg(RegSatEn, {15'd0, sat});
  endtask

  task automatic wait_idle();
    while (sample_queue.size() > 0 || in_if.valid || expected_beats.size() > 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // A loud attack of a few beats followed by a decaying tail, or noise.
  task automatic queue_random(int n);
    int left, burst, sgn, peak;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 9) < 7) begin
        peak = $urandom_range(4194304, 8388608);
        burst = $urandom_range(1, 4);
        repeat (burst) begin
          sgn = $urandom_range(0, 1);
          sample_queue.push_back(24'(sgn ? -peak : (peak > 8388607 ? 8388607 : peak)));
          left--;
        end
        burst = $urandom_range(5, 30);
        repeat (burst) begin
          peak = peak / 2 + $urandom_range(0, 1023);
          sgn = $urandom_range(0, 1);
          sample_queue.push_back(24'(sgn ? -peak : peak));
          left--;
        end
      end else begin
        sample_queue.push_back(24'($urandom()));
        left--;
      end
    end
  endtask

  initial begin
    fast_k_reg = 16'd0;
    slow_k_reg = 16'd0;
    gain_reg   = 16'd8192;
    sat_reg    = 1'b0;
    fast_env   = 0;
    slow_env   = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: extremes, equal magnitude, held envelopes.
    sample_queue.push_back(24'h000000);
    sample_queue.push_back(24'h7FFFFF);
    sample_queue.push_back(24'h800000);
    sample_queue.push_back(24'h800001);
    sample_queue.push_back(24'h7FFFFF);
    sample_queue.push_back(24'd100);
    sample_queue.push_back(24'd100);
    wait_idle();

    // Slow decays faster than fast: transient present, soft clipper engaged.
    configure(16'd0, 16'hFFFF, 16'hFFFF, 1'b1);
    sample_queue.push_back(24'h800000);
    sample_queue.push_back(24'h000000);
    sample_queue.push_back(24'h000000);
    sample_queue.push_back(24'h7FFFFF);
    sample_queue.push_back(24'h400000);
    sample_queue.push_back(24'h000001);
    sample_queue.push_back(24'hFFFFFF);
    wait_idle();

    // Equal coefficient settings, fast scaled above slow: slow stays high, no transient.
    configure(16'hFFFF, 16'hFFFF, 16'd0, 1'b0);
    sample_queue.push_back(24'h7FFFFF);
    sample_queue.push_back(24'h000010);
    sample_queue.push_back(24'h800000);
    sample_queue.push_back(24'h000000);
    wait_idle();

    // Random phases; the receiver holds off for a long stretch in the second.
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: configure(16'd1000, 16'd60000, 16'hFFFF, 1'b1);
        3: configure(16'hFFFF, 16'd0, 16'd8192, 1'b1);
        default: configure(16'($urandom()), 16'($urandom()), 16'($urandom()),
                           1'($urandom_range(0, 1)));
      endcase
      if (p == 6) quiet = 1'b1;
      queue_random(200);
      if (p == 1) hold_req = 1'b1;
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+src
src/ts_pkg.sv
src/ts_stream_if.sv
src/ts_front.sv
src/ts_queue.sv
src/ts_back.sv
src/transient_shaper.sv
dv/tb.sv
